/* rtl/mmrm_pkg.sv */
// shared types and constants of the memory map range merger
package mmrm_pkg;

    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned PAGES_W    = 52;
    localparam int unsigned MASK_W     = 16;
    localparam int unsigned PADDR_W    = 3;

    localparam logic [PAGES_W-1:0] PAGES_MAX = '1;

    localparam logic [MASK_W-1:0] JOIN_MASK_RESET = 16'd24;

    localparam logic REG_JOIN_MASK = 1'b0;

    typedef struct packed {
        logic [31:0]        mem_type;
        logic [63:0]        phys;
        logic [63:0]        virt;
        logic [PAGES_W-1:0] pages;
        logic [63:0]        attr;
        logic               last;
    } desc_t;

    typedef struct packed {
        logic [1:0] cnt;
        desc_t      w0;
        desc_t      w1;
    } push_t;

endpackage

/* rtl/mmrm_if.sv */
// descriptor input and output channel interfaces
interface mmrm_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] mem_type;
    logic [63:0] phys_start;
    logic [63:0] virt_start;
    logic [51:0] page_count;
    logic [63:0] attributes;
    logic        last_entry;

    modport source (output valid, mem_type, phys_start, virt_start, page_count, attributes,
                    last_entry, input ready);
    modport sink (input valid, mem_type, phys_start, virt_start, page_count, attributes,
                  last_entry, output ready);
endinterface

interface mmrm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_type;
    logic [63:0] out_phys_start;
    logic [63:0] out_virt_start;
    logic [51:0] out_pages;
    logic [63:0] out_attributes;
    logic        out_last;

    modport source (output valid, out_type, out_phys_start, out_virt_start, out_pages,
                    out_attributes, out_last, input ready);
    modport sink (input valid, out_type, out_phys_start, out_virt_start, out_pages,
                  out_attributes, out_last, output ready);
endinterface

/* rtl/mmrm_front.sv */
// front part: accepts descriptors, compares against the pending range, pushes words
module mmrm_front (
    input  logic                        clk,
    input  logic                        rst_n,
    mmrm_in_if.sink                     desc_in,
    input  logic [mmrm_pkg::MASK_W-1:0] join_mask,
    input  logic                        space_ok,
    output mmrm_pkg::push_t             push
);
    import mmrm_pkg::*;

    desc_t             pend_reg;
    desc_t             pend_next;
    logic              pv_reg;
    logic              pv_next;
    desc_t             in_word;
    logic              accept;
    logic [63:0]       pend_end;
    logic              in_ok;
    logic              pend_ok;
    logic              join_hit;
    logic [PAGES_W:0]  sum;
    logic [PAGES_W-1:0] sat_pages;

    assign desc_in.ready = space_ok;
    assign accept = desc_in.valid && space_ok;

    assign in_word.mem_type = desc_in.mem_type;
    assign in_word.phys     = desc_in.phys_start;
    assign in_word.virt     = desc_in.virt_start;
    assign in_word.pages    = desc_in.page_count;
    assign in_word.attr     = desc_in.attributes;
    assign in_word.last     = desc_in.last_entry;

    assign pend_end = pend_reg.phys + {pend_reg.pages, {PAGE_SHIFT{1'b0}}};
    assign in_ok    = (in_word.mem_type[31:4] == '0) && join_mask[in_word.mem_type[3:0]];
    assign pend_ok  = (pend_reg.mem_type[31:4] == '0) && join_mask[pend_reg.mem_type[3:0]];
    assign join_hit = (in_word.attr == pend_reg.attr) && (pend_end == in_word.phys)
                      && in_ok && pend_ok;

    assign sum       = {1'b0, pend_reg.pages} + {1'b0, in_word.pages};
    assign sat_pages = sum[PAGES_W] ? PAGES_MAX : sum[PAGES_W-1:0];

    always_comb
    begin
        push      = '0;
        pend_next = pend_reg;
        pv_next   = pv_reg;
        if (accept)
        begin
            if (!pv_reg)
            begin
                pend_next = in_word;
                if (in_word.last)
                begin
                    push.cnt     = 2'd1;
                    push.w0      = in_word;
                    push.w0.last = 1'b1;
                    pv_next      = 1'b0;
                end
                else
                begin
                    pv_next = 1'b1;
                end
            end
            else if (join_hit)
            begin
                pend_next.pages = sat_pages;
                if (in_word.last)
                begin
                    push.cnt      = 2'd1;
                    push.w0       = pend_reg;
                    push.w0.pages = sat_pages;
                    push.w0.last  = 1'b1;
                    pv_next       = 1'b0;
                end
            end
            else
            begin
                push.cnt     = 2'd1;
                push.w0      = pend_reg;
                push.w0.last = 1'b0;
                pend_next    = in_word;
                if (in_word.last)
                begin
                    push.cnt     = 2'd2;
                    push.w1      = in_word;
                    push.w1.last = 1'b1;
                    pv_next      = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

`ifndef SYNTH
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && desc_in.last_entry |=> !pv_reg)
        else $error("pending range survives a last entry");
    a_first_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !pv_reg && !desc_in.last_entry |-> push.cnt == 2'd0 ##1 pv_reg)
        else $error("first descriptor not held pending");
    a_two_words: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd2 |-> accept && pv_reg && desc_in.last_entry && !join_hit)
        else $error("two words pushed outside a break on the last entry");
`endif

endmodule

/* rtl/mmrm_queue.sv */
// short word queue between front and back, takes up to two words a cycle
module mmrm_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mmrm_pkg::push_t push,
    output logic            space_ok,
    output logic            head_valid,
    output mmrm_pkg::desc_t head,
    input  logic            pop
);
    import mmrm_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    desc_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign space_ok   = count_reg <= CNT_W'(DEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        case (push.cnt)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.cnt) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= push.w0;
        if (push.cnt == 2'd2)
            mem_reg[wr_ptr_inc] <= push.w1;
    end

endmodule

/* rtl/mmrm_back.sv */
// back part: output register that hands queued words to the result channel
module mmrm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  mmrm_pkg::desc_t head,
    output logic            pop,
    mmrm_out_if.source      desc_out
);
    import mmrm_pkg::*;

    desc_t out_reg;
    logic  out_valid_reg;
    logic  out_valid_next;

    assign pop            = head_valid && (!out_valid_reg || desc_out.ready);
    assign out_valid_next = pop || (out_valid_reg && !desc_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= head;
    end

    assign desc_out.valid          = out_valid_reg;
    assign desc_out.out_type       = out_reg.mem_type;
    assign desc_out.out_phys_start = out_reg.phys;
    assign desc_out.out_virt_start = out_reg.virt;
    assign desc_out.out_pages      = out_reg.pages;
    assign desc_out.out_attributes = out_reg.attr;
    assign desc_out.out_last       = out_reg.last;

endmodule

/* rtl/memory_map_range_merger_unit.sv */
// top level of the memory map range merger with its register port
// a word is queued when its completing descriptor is accepted, then loaded into out_reg
// throughput: one descriptor accepted and one word delivered per cycle while not stalled
// input is taken while the word queue has two free slots; pending compare is combinational
// reset: pending range, queue and output register empty, join mask at 24
module memory_map_range_merger_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mmrm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    mmrm_in_if.sink                      desc_in,
    mmrm_out_if.source                   desc_out
);
    import mmrm_pkg::*;

    logic [MASK_W-1:0] join_mask_reg;
    logic              mask_sel;
    push_t             push;
    logic              space_ok;
    logic              head_valid;
    desc_t             head;
    logic              pop;

    assign pready   = 1'b1;
    assign mask_sel = paddr[2] == REG_JOIN_MASK;
    assign prdata   = mask_sel ? {{(32 - MASK_W){1'b0}}, join_mask_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            join_mask_reg <= JOIN_MASK_RESET;
        end
        else if (psel && penable && pwrite && mask_sel)
        begin
            join_mask_reg <= pwdata[MASK_W-1:0];
        end
    end

    mmrm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .desc_in   (desc_in),
        .join_mask (join_mask_reg),
        .space_ok  (space_ok),
        .push      (push)
    );

    mmrm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space_ok   (space_ok),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    mmrm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .desc_out   (desc_out)
    );

endmodule

/* verif/tb.sv */
// self-checking testbench of the memory map range merger
`timescale 1ns / 1ps

module tb;

    import mmrm_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int TIMEOUT_CYCLES   = 200000;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int PHASE_ITEMS      = 180;

    localparam logic [PADDR_W-1:0] ADDR_JOIN_MASK = PADDR_W'(4 * REG_JOIN_MASK);
    localparam logic [PADDR_W-1:0] ADDR_NO_REG    = PADDR_W'(4);

    class range_merge_scoreboard;
        logic [MASK_W-1:0] join_mask;
        bit                run_open;
        desc_t             run;
        desc_t             merged_words[$];
        int unsigned       errors;
        int unsigned       words_checked;
        int unsigned       descs_noted;
        int unsigned       maps_closed;
        int unsigned       joins;
        int unsigned       saturations;
        int unsigned       mask_settings;

        function new();
            join_mask     = JOIN_MASK_RESET;
            run_open      = 1'b0;
            run           = '0;
            errors        = 0;
            words_checked = 0;
            descs_noted   = 0;
            maps_closed   = 0;
            joins         = 0;
            saturations   = 0;
            mask_settings = 0;
        endfunction

        function void set_mask(logic [31:0] value);
            join_mask = value[MASK_W-1:0];
            mask_settings++;
        endfunction

        function bit joinable(logic [31:0] t);
            return (t < 16) && join_mask[t[3:0]];
        endfunction

        function void close_run();
            run.last = 1'b1;
            merged_words.push_back(run);
            run_open = 1'b0;
            maps_closed++;
        endfunction

        function void note_desc(desc_t d);
            logic [63:0]      range_end;
            logic [PAGES_W:0] sum;
            bit               can_join;
            descs_noted++;
            if (!run_open)
            begin
                run      = d;
                run.last = 1'b0;
                run_open = 1'b1;
                if (d.last)
                    close_run();
                return;
            end
            range_end = run.phys + {run.pages, 12'h000};
            can_join  = (d.attr == run.attr) && (range_end == d.phys) &&
                        joinable(d.mem_type) && joinable(run.mem_type);
            if (can_join)
            begin
                joins++;
                sum = {1'b0, run.pages} + {1'b0, d.pages};
                if (sum[PAGES_W])
                begin
                    run.pages = PAGES_MAX;
                    saturations++;
                end
                else
                    run.pages = sum[PAGES_W-1:0];
                if (d.last)
                    close_run();
                return;
            end
            run.last = 1'b0;
            merged_words.push_back(run);
            run      = d;
            run.last = 1'b0;
            if (d.last)
                close_run();
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(desc_t got);
            desc_t want;
            if (merged_words.size() == 0)
            begin
                $display("%0t: unexpected word, type %h phys %h pages %h last %b",
                         $time, got.mem_type, got.phys, got.pages, got.last);
                errors++;
                return;
            end
            want = merged_words.pop_front();
            words_checked++;
            check_field("type", 64'(want.mem_type), 64'(got.mem_type));
            check_field("phys_start", want.phys, got.phys);
            check_field("virt_start", want.virt, got.virt);
            check_field("pages", 64'(want.pages), 64'(got.pages));
            check_field("attributes", want.attr, got.attr);
            check_field("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    mmrm_in_if  desc_in_if ();
    mmrm_out_if desc_out_if ();

    range_merge_scoreboard sb;

    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned hold_requests;

    memory_map_range_merger_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .desc_in  (desc_in_if),
        .desc_out (desc_out_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Verification failed");
        $finish;
    end

    // output side: check accepted words and drive ready
    initial
    begin
        int unsigned hold_left;
        int unsigned holds_seen;
        desc_t       got;
        hold_left  = 0;
        holds_seen = 0;
        desc_out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && desc_out_if.valid && desc_out_if.ready)
            begin
                got.mem_type = desc_out_if.out_type;
                got.phys     = desc_out_if.out_phys_start;
                got.virt     = desc_out_if.out_virt_start;
                got.pages    = desc_out_if.out_pages;
                got.attr     = desc_out_if.out_attributes;
                got.last     = desc_out_if.out_last;
                sb.check_word(got);
            end
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                desc_out_if.ready <= 1'b0;
            end
            else
                desc_out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic verify_mask_readback();
        logic [31:0] value;
        apb_read(ADDR_JOIN_MASK, value);
        if (value !== {{(32 - MASK_W){1'b0}}, sb.join_mask})
        begin
            $display("%0t: join mask readback mismatch, expected %h, got %h",
                     $time, sb.join_mask, value);
            sb.errors++;
        end
    endtask

    task automatic wait_idle();
        int unsigned waited;
        waited = 0;
        desc_in_if.valid <= 1'b0;
        while (sb.merged_words.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.merged_words.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, sb.merged_words.size());
            sb.errors++;
            sb.merged_words.delete();
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_join_mask(input logic [31:0] value);
        wait_idle();
        apb_write(ADDR_JOIN_MASK, value);
        sb.set_mask(value);
        verify_mask_readback();
    endtask

    task automatic send_desc(input desc_t d);
        while ($urandom_range(99) < src_idle_pct)
        begin
            desc_in_if.valid <= 1'b0;
            @(posedge clk);
        end
        desc_in_if.valid      <= 1'b1;
        desc_in_if.mem_type   <= d.mem_type;
        desc_in_if.phys_start <= d.phys;
        desc_in_if.virt_start <= d.virt;
        desc_in_if.page_count <= d.pages;
        desc_in_if.attributes <= d.attr;
        desc_in_if.last_entry <= d.last;
        @(posedge clk);
        while (!desc_in_if.ready)
            @(posedge clk);
        sb.note_desc(d);
    endtask

    task automatic send_fields(input logic [31:0] t, input logic [63:0] p,
                               input logic [PAGES_W-1:0] n, input logic [63:0] a,
                               input logic l);
        desc_t d;
        d.mem_type = t;
        d.phys     = p;
        d.virt     = {$urandom, $urandom};
        d.pages    = n;
        d.attr     = a;
        d.last     = l;
        send_desc(d);
    endtask

    function automatic logic [31:0] pick_joinable_type();
        logic [31:0] t;
        if (sb.join_mask == '0)
            return $urandom_range(0, 15);
        t = $urandom_range(0, 15);
        while (!sb.join_mask[t[3:0]])
            t = $urandom_range(0, 15);
        return t;
    endfunction

    task automatic send_random_maps(input int unsigned n_items);
        desc_t       d;
        logic [63:0] tail_end;
        logic [63:0] tail_attr;
        bit          have_tail;
        int unsigned left_in_map;
        int unsigned r;
        have_tail   = 1'b0;
        left_in_map = 0;
        tail_end    = '0;
        tail_attr   = '0;
        for (int unsigned i = 0; i < n_items; i++)
        begin
            if (left_in_map == 0)
                left_in_map = $urandom_range(1, 12);
            r = $urandom_range(99);
            if (r < 50)
                d.mem_type = pick_joinable_type();
            else if (r < 75)
                d.mem_type = $urandom_range(0, 15);
            else if (r < 90)
                d.mem_type = $urandom_range(16, 40);
            else
                d.mem_type = $urandom;
            r = $urandom_range(99);
            if (r < 70)
                d.phys = {$urandom, 20'($urandom_range(0, 32'hFFFFF)), 12'h000};
            else if (r < 85)
                d.phys = {32'hFFFF_FFFF, $urandom};
            else
                d.phys = {$urandom, $urandom};
            d.virt = {$urandom, $urandom};
            r = $urandom_range(99);
            if (r < 70)
                d.pages = $urandom_range(0, 64);
            else if (r < 85)
                d.pages = {20'($urandom), $urandom};
            else
                d.pages = PAGES_MAX - $urandom_range(0, 8);
            r = $urandom_range(99);
            if (r < 20)
                d.attr = '0;
            else if (r < 35)
                d.attr = '1;
            else if (r < 50)
                d.attr = 64'h0000_0000_0000_000F;
            else
                d.attr = {$urandom, $urandom};
            if (have_tail && $urandom_range(99) < 70)
            begin
                d.phys = tail_end;
                d.attr = tail_attr;
                if ($urandom_range(99) < 85)
                    d.mem_type = pick_joinable_type();
            end
            left_in_map--;
            d.last = (left_in_map == 0) || (i == n_items - 1);
            send_desc(d);
            tail_end  = d.phys + {d.pages, 12'h000};
            tail_attr = d.attr;
            have_tail = !d.last;
        end
    endtask

    initial
    begin
        sb = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_requests  = 0;
        rst_n   = 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        desc_in_if.valid      <= 1'b0;
        desc_in_if.mem_type   <= '0;
        desc_in_if.phys_start <= '0;
        desc_in_if.virt_start <= '0;
        desc_in_if.page_count <= '0;
        desc_in_if.attributes <= '0;
        desc_in_if.last_entry <= 1'b0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        verify_mask_readback();

        // single-entry map with address, page count and attributes at their top
        send_fields(32'd3, '1, PAGES_MAX, '1, 1'b1);
        // joins, an attribute break, and a break on the last entry
        send_fields(32'd3, 64'h1000, 52'd2, 64'hA5, 1'b0);
        send_fields(32'd4, 64'h3000, 52'd1, 64'hA5, 1'b0);
        send_fields(32'd3, 64'h4000, 52'd1, 64'h5A, 1'b0);
        send_fields(32'd4, 64'h5000, 52'd3, 64'h5A, 1'b0);
        send_fields(32'd5, 64'h8000, 52'd1, 64'h5A, 1'b1);
        // page count saturation
        send_fields(32'd3, 64'h0, PAGES_MAX - 52'd1, 64'h0, 1'b0);
        send_fields(32'd4, {PAGES_MAX - 52'd1, 12'h000}, 52'd5, 64'h0, 1'b0);
        send_fields(32'd3, {PAGES_MAX, 12'h000}, 52'd1, 64'h0, 1'b1);
        // address wrap and zero page counts
        send_fields(32'd4, 64'hFFFF_FFFF_FFFF_E000, 52'd2, '1, 1'b0);
        send_fields(32'd3, 64'h0, 52'd4, '1, 1'b0);
        send_fields(32'd3, 64'h4000, 52'd0, '1, 1'b0);
        send_fields(32'd3, 64'h4000, 52'd0, '1, 1'b0);
        send_fields(32'd5, 64'h4000, 52'd0, '1, 1'b0);
        // mask change with a run open, then types with no mask bit
        set_join_mask(32'h0000_FFFF);
        send_fields(32'd5, 64'h4000, 52'd7, '1, 1'b0);
        send_fields(32'd16, 64'hB000, 52'd1, '1, 1'b0);
        send_fields(32'hFFFF_FFFF, 64'hC000, 52'd1, '1, 1'b1);
        // nothing joins with an empty mask
        set_join_mask(32'h0);
        send_fields(32'd0, 64'h0, 52'd1, 64'h0, 1'b0);
        send_fields(32'd0, 64'h1000, 52'd1, 64'h0, 1'b1);
        // write to an address with no register behind it
        wait_idle();
        apb_write(ADDR_NO_REG, $urandom);
        verify_mask_readback();

        set_join_mask($urandom_range(0, 65535));
        send_random_maps(20);
        hold_requests++;
        send_random_maps(PHASE_ITEMS - 20);

        set_join_mask(32'h0000_FFFF);
        src_idle_pct   = 60;
        sink_stall_pct = 0;
        send_random_maps(PHASE_ITEMS);

        set_join_mask(32'(JOIN_MASK_RESET));
        src_idle_pct   = 0;
        sink_stall_pct = 60;
        send_random_maps(PHASE_ITEMS);

        set_join_mask($urandom_range(0, 65535));
        src_idle_pct   = 32;
        sink_stall_pct = 32;
        send_random_maps(PHASE_ITEMS);

        wait_idle();
        $display("covered %0d descriptors in %0d maps, %0d merged words checked",
                 sb.descs_noted, sb.maps_closed, sb.words_checked);
        $display("%0d joins, %0d saturated page counts, %0d join mask settings",
                 sb.joins, sb.saturations, sb.mask_settings);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
